[design/pscalc_pkg.sv]
// Shared constants, codes and types for the postfix stack calculator.
package pscalc_pkg;

    localparam int DATA_W              = 32;
    localparam int CMD_W               = 3;
    localparam int STATUS_W            = 3;
    localparam int DEPTH_W             = 7;
    localparam int DEFAULT_STACK_DEPTH = 64;

    // Value returned in place of a missing stack entry.
    localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FF80;

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd4;

    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_DIV = 2'd3;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_req_t;

endpackage

[design/postfix_stack_calculator_core.sv]
// Top level of the postfix stack calculator: token sequencer, stack and shared unit.
// A push or ignored token goes from decode to the done state; a pop adds a stack read
// state, and add, subtract, multiply and floor divide add operand fetch, execute and a
// wait on the unit (32 divider steps plus a sign fix-up for a divide). A new transaction
// is taken once the previous one has reached the result register; the divider is the slowest.
// Reset (rst_n, asynchronous, active low) empties the stack and clears the halt flag;
// stack entries are not cleared and need no pass after reset.
module postfix_stack_calculator_core #(
    parameter int STACK_DEPTH = pscalc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  logic [pscalc_pkg::CMD_W-1:0]           command,
    input  logic signed [pscalc_pkg::DATA_W-1:0]   operand,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic [pscalc_pkg::STATUS_W-1:0]        status,
    output logic signed [pscalc_pkg::DATA_W-1:0]   value,
    output logic [pscalc_pkg::DEPTH_W-1:0]         depth
);
    import pscalc_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_TAKE_L = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_POPRD  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Control state
    logic [2:0]          state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic                halted_reg, halted_next;
    logic                under_reg, under_next;
    logic                rpend_reg, rpend_next;
    logic                lpend_reg, lpend_next;
    logic                res_valid_reg, res_valid_next;

    // Working and result payload
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [DATA_W-1:0]   opnd_reg, opnd_next;
    logic [DATA_W-1:0]   right_reg, right_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_value_reg, res_value_next;
    logic [DEPTH_W-1:0]  res_depth_reg, res_depth_next;

    // Stack and unit connections
    logic                wr_en;
    logic [DATA_W-1:0]   wr_data;
    logic                rd_en;
    logic [DATA_W-1:0]   rd_data;
    logic [SP_W-1:0]     sp_dec;
    alu_req_t            alu_req;
    logic [DATA_W-1:0]   alu_a;
    logic                alu_done;
    logic [DATA_W-1:0]   alu_result;
    logic                res_free;

    assign sp_dec   = sp_reg - 1'b1;
    assign res_free = !res_valid_reg || result_ready;
    assign item_ready = (state_reg == S_IDLE);
    // Left operand comes straight from the stack read, or the empty marker.
    assign alu_a = lpend_reg ? rd_data : EMPTY_VALUE;

    pscalc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (sp_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (sp_dec[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    pscalc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (right_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        halted_next     = halted_reg;
        under_next      = under_reg;
        rpend_next      = rpend_reg;
        lpend_next      = lpend_reg;
        cmd_next        = cmd_reg;
        opnd_next       = opnd_reg;
        right_next      = right_reg;
        stat_next       = stat_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_depth_next  = res_depth_reg;
        // Drop the held result once the consumer takes it.
        res_valid_next  = res_valid_reg && !result_ready;

        wr_en         = 1'b0;
        wr_data       = opnd_reg;
        rd_en         = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = 2'(cmd_reg - CMD_ADD);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next   = command;
                    opnd_next  = operand;
                    under_next = 1'b0;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                stat_next  = ST_OK;
                val_next   = '0;
                state_next = S_DONE;
                if (halted_reg)
                begin
                    stat_next = ST_HALTED;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_PUSH:
                        begin
                            val_next = opnd_reg;
                            if (sp_reg < SP_FULL)
                            begin
                                wr_en   = 1'b1;
                                sp_next = sp_reg + 1'b1;
                            end
                            else
                            begin
                                stat_next = ST_OVER;
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                        begin
                            // Take the right operand from the top.
                            state_next = S_TAKE_L;
                            if (sp_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                sp_next    = sp_dec;
                                rpend_next = 1'b1;
                            end
                            else
                            begin
                                rpend_next = 1'b0;
                                under_next = 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (sp_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                sp_next    = sp_dec;
                                state_next = S_POPRD;
                            end
                            else
                            begin
                                stat_next = ST_UNDER;
                                val_next  = EMPTY_VALUE;
                            end
                        end
                        default:
                        begin
                            // Unused codes: ignore the token.
                            stat_next = ST_OK;
                        end
                    endcase
                end
            end

            S_TAKE_L:
            begin
                right_next = rpend_reg ? rd_data : EMPTY_VALUE;
                if (sp_reg != '0)
                begin
                    rd_en      = 1'b1;
                    sp_next    = sp_dec;
                    lpend_next = 1'b1;
                end
                else
                begin
                    lpend_next = 1'b0;
                    under_next = 1'b1;
                end
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                if ((cmd_reg == CMD_DIV) && (right_reg == '0))
                begin
                    // Both operands stay popped; halt until reset.
                    halted_next = 1'b1;
                    stat_next   = ST_DIVZERO;
                    val_next    = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    state_next    = S_WAIT;
                end
            end

            S_WAIT:
            begin
                if (alu_done)
                begin
                    val_next  = alu_result;
                    stat_next = under_reg ? ST_UNDER : ST_OK;
                    wr_data   = alu_result;
                    if (sp_reg < SP_FULL)
                    begin
                        wr_en   = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end
            end

            S_POPRD:
            begin
                val_next   = rd_data;
                stat_next  = ST_OK;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the result register is free.
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = stat_reg;
                    res_value_next  = val_reg;
                    res_depth_next  = DEPTH_W'(sp_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            halted_reg    <= 1'b0;
            under_reg     <= 1'b0;
            rpend_reg     <= 1'b0;
            lpend_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halted_reg    <= halted_next;
            under_reg     <= under_next;
            rpend_reg     <= rpend_next;
            lpend_reg     <= lpend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        opnd_reg       <= opnd_next;
        right_reg      <= right_next;
        stat_reg       <= stat_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_depth_reg  <= res_depth_next;
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign value        = res_value_reg;
    assign depth        = res_depth_reg;

endmodule

[design/pscalc_stack.sv]
// Operand stack storage: one write port and one registered read port.
module pscalc_stack #(
    parameter int STACK_DEPTH = pscalc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0]    wr_addr,
    input  logic [pscalc_pkg::DATA_W-1:0]     wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(STACK_DEPTH)-1:0]    rd_addr,
    output logic [pscalc_pkg::DATA_W-1:0]     rd_data
);
    import pscalc_pkg::*;

    logic [DATA_W-1:0] mem_reg [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/pscalc_alu.sv]
// Shared arithmetic unit: add, subtract, multiply registered from the request; iterative floor divide.
module pscalc_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pscalc_pkg::alu_req_t          req,
    input  logic [pscalc_pkg::DATA_W-1:0] a,
    input  logic [pscalc_pkg::DATA_W-1:0] b,
    output logic                          done,
    output logic [pscalc_pkg::DATA_W-1:0] result
);
    import pscalc_pkg::*;

    logic              busy_reg, busy_next;
    logic              fix_reg, fix_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] result_reg, result_next;

    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] q_trunc;
    logic [DATA_W-1:0] product;

    assign product = a * b;
    assign trial   = {rem_reg, dvd_reg[DATA_W-1]} - {1'b0, dvs_reg};
    assign q_trunc = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        fix_next    = 1'b0;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        result_next = result_reg;

        if (req.start)
        begin
            case (req.op)
                ALU_ADD:
                begin
                    result_next = a + b;
                    done_next   = 1'b1;
                end
                ALU_SUB:
                begin
                    result_next = a - b;
                    done_next   = 1'b1;
                end
                ALU_MUL:
                begin
                    result_next = product;
                    done_next   = 1'b1;
                end
                default:
                begin
                    // Divide magnitudes; signs are applied in the fix-up cycle.
                    busy_next = 1'b1;
                    cnt_next  = 5'd31;
                    rem_next  = '0;
                    dvd_next  = a[DATA_W-1] ? (~a + 1'b1) : a;
                    dvs_next  = b[DATA_W-1] ? (~b + 1'b1) : b;
                    neg_next  = a[DATA_W-1] ^ b[DATA_W-1];
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], dvd_reg[DATA_W-1]};
            end
            dvd_next = {dvd_reg[DATA_W-2:0], ~trial[DATA_W]};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            // Round toward minus infinity when inexact and signs differ.
            result_next = (neg_reg && (rem_reg != '0)) ? (q_trunc - 1'b1) : q_trunc;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[tb/tb_postfix_stack_calculator_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the postfix stack calculator core with a queued driver.
module tb_postfix_stack_calculator_core;

    import pscalc_pkg::*;

    // Stack size of the device under test and of the shadow calculator.
    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;

    // Unused command codes: the core must answer ok and leave the stack alone.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    localparam int RANDOM_TOKENS  = 1350; // random tokens that reach the stack logic
    localparam int TAIL_ITEMS     = 150;  // last stretch of the run driven without idling
    localparam int HOLD_AFTER     = 300;  // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES    = 250;  // length of that hold-off
    localparam int DRAIN_CYCLES   = 60;   // quiet time after the last result
    // Longest correct stretch without a transaction is the hold-off plus one divide.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] opnd;
    } token_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   value;
        logic [DEPTH_W-1:0]  depth;
    } calc_result_t;

    // Shadow of the calculator: stack contents, entry count and halt flag.
    typedef struct packed {
        logic [STACK_DEPTH-1:0][DATA_W-1:0] slots;
        logic [DEPTH_W-1:0]                 fill;
        logic                               halted;
    } calc_state_t;

    // DUT connections; every input starts at a known value.
    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_ready;
    logic [CMD_W-1:0]         command      = CMD_PUSH;
    logic signed [DATA_W-1:0] operand      = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value;
    logic [DEPTH_W-1:0]       depth;

    token_t       pending_tokens[$];   // tokens waiting to be offered
    calc_result_t expected_results[$]; // predicted results, oldest first

    calc_state_t  plan_state;          // shadow used while building the stimulus
    calc_state_t  live_state;          // shadow advanced on each accepted token
    bit           div_zero_allowed = 1'b0;
    int           planned_tokens   = 0;

    int           send_gap        = 0;
    int           recv_gap        = 0;
    int           hold_left       = 0;
    bit           long_hold_done  = 1'b0;
    int           results_seen    = 0;
    int           fail_count      = 0;
    int           quiet_cycles    = 0;
    bit           item_fire;

    postfix_stack_calculator_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .operand      (operand),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .value        (value),
        .depth        (depth)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Take the top entry; stand in the empty value and flag underflow when there is none.
    function automatic logic [DATA_W-1:0] take_top(inout calc_state_t st, inout bit missing);
        if (st.fill != 0)
        begin
            st.fill = st.fill - 1'b1;
            return st.slots[st.fill];
        end
        missing = 1'b1;
        return EMPTY_VALUE;
    endfunction

    // Advance a shadow stack by one token and return the result the core should give.
    function automatic calc_result_t apply_token(inout calc_state_t st, input token_t tok);
        calc_result_t      res;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] lhs;
        longint            num;
        longint            den;
        longint            quot;
        bit                missing;
        bit                keep;
        res.status = ST_OK;
        res.value  = '0;
        missing    = 1'b0;
        keep       = 1'b1;
        if (st.halted)
        begin
            res.status = ST_HALTED;
        end
        else if (tok.cmd == CMD_PUSH)
        begin
            res.value = tok.opnd;
            if (st.fill < STACK_DEPTH)
            begin
                st.slots[st.fill] = tok.opnd;
                st.fill = st.fill + 1'b1;
            end
            else
            begin
                res.status = ST_OVER;
            end
        end
        else if (tok.cmd >= CMD_ADD && tok.cmd <= CMD_DIV)
        begin
            // The top entry is the right operand, the one below it the left.
            rhs = take_top(st, missing);
            lhs = take_top(st, missing);
            case (tok.cmd)
                CMD_ADD: res.value = lhs + rhs;
                CMD_SUB: res.value = lhs - rhs;
                CMD_MUL: res.value = lhs * rhs;
                default:
                begin
                    if (rhs == '0)
                    begin
                        // Divide by zero wins over underflow and halts the core.
                        keep       = 1'b0;
                        st.halted  = 1'b1;
                        res.status = ST_DIVZERO;
                    end
                    else
                    begin
                        // Floor division: lower a truncated quotient when signs differ.
                        num  = longint'($signed(lhs));
                        den  = longint'($signed(rhs));
                        quot = num / den;
                        if ((num % den) != 0 && ((num < 0) != (den < 0)))
                            quot = quot - 1;
                        res.value = quot[DATA_W-1:0];
                    end
                end
            endcase
            if (keep)
            begin
                if (st.fill < STACK_DEPTH)
                begin
                    st.slots[st.fill] = res.value;
                    st.fill = st.fill + 1'b1;
                end
                if (missing)
                    res.status = ST_UNDER;
            end
        end
        else if (tok.cmd == CMD_POP)
        begin
            res.value = take_top(st, missing);
            if (missing)
                res.status = ST_UNDER;
        end
        res.depth = st.fill;
        return res;
    endfunction

    // Queue a token for the driver and advance the planning shadow.
    // Steer a random divide away from a zero divisor until the halt is wanted.
    task automatic plan_token(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] opnd);
        token_t tok;
        tok.cmd  = cmd;
        tok.opnd = opnd;
        if (cmd == CMD_DIV && !div_zero_allowed && plan_state.fill != 0
            && plan_state.slots[plan_state.fill - 1'b1] == '0)
            tok.cmd = CMD_ADD;
        void'(apply_token(plan_state, tok));
        pending_tokens = {pending_tokens, tok};
        if (tok.cmd <= CMD_POP)
            planned_tokens++;
    endtask

    // Mix extremes, small values that make exact and inexact quotients, and full-width noise.
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return DATA_W'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom();
        endcase
    endfunction

    // Driver: offer queued tokens, hold each until accepted, and insert idle bursts.
    // Predict the result of every accepted transaction in acceptance order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            command    <= CMD_PUSH;
            operand    <= '0;
            send_gap   <= 0;
        end
        else
        begin
            item_fire = item_valid && item_ready;
            if (item_fire)
                expected_results = {expected_results,
                                    apply_token(live_state, {command, operand})};
            if (item_valid && !item_fire)
            begin
                // hold the offered token until the core takes it
            end
            else if (send_gap > 0)
            begin
                send_gap   <= send_gap - 1;
                item_valid <= 1'b0;
            end
            else if (pending_tokens.size() != 0)
            begin
                if (pending_tokens.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
                begin
                    send_gap   <= $urandom_range(0, 8);
                    item_valid <= 1'b0;
                end
                else
                begin
                    item_valid <= 1'b1;
                    command    <= pending_tokens[0].cmd;
                    operand    <= pending_tokens[0].opnd;
                    void'(pending_tokens.pop_front());
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off to back the core up, none at the tail.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready   <= 1'b0;
            recv_gap       <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= HOLD_AFTER)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= HOLD_CYCLES - 1;
            result_ready   <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap     <= recv_gap - 1;
            result_ready <= 1'b0;
        end
        else if (pending_tokens.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0)
        begin
            recv_gap     <= $urandom_range(0, 8);
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Monitor: compare each result transaction with the oldest prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("result with no prediction pending: status %0d value %0d depth %0d",
                       status, value, depth);
                fail_count++;
            end
            else
            begin
                if (status !== expected_results[0].status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           expected_results[0].status, status);
                    fail_count++;
                end
                if (value !== expected_results[0].value)
                begin
                    $error("value mismatch: expected %0d, actual %0d",
                           $signed(expected_results[0].value), value);
                    fail_count++;
                end
                if (depth !== expected_results[0].depth)
                begin
                    $error("depth mismatch: expected %0d, actual %0d",
                           expected_results[0].depth, depth);
                    fail_count++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int target;
        int shape;
        int len;
        plan_state = '0;
        live_state = '0;

        // Directed opening on an empty stack: underflow on pop and on a combination.
        plan_token(CMD_POP, 32'h0000_1234);
        plan_token(CMD_ADD, '0);
        plan_token(CMD_POP, '1);
        // Wrap on add, then the most negative value divided by minus one.
        plan_token(CMD_PUSH, INT_MAX);
        plan_token(CMD_PUSH, 32'd1);
        plan_token(CMD_ADD, INT_MAX);
        plan_token(CMD_PUSH, '1);
        plan_token(CMD_DIV, '0);
        // Floor division with differing signs, both ways round.
        plan_token(CMD_PUSH, -32'sd7);
        plan_token(CMD_PUSH, 32'd2);
        plan_token(CMD_DIV, '0);
        plan_token(CMD_PUSH, 32'd3);
        plan_token(CMD_SUB, '0);
        plan_token(CMD_MUL, '0);
        plan_token(CMD_PUSH, 32'd7);
        plan_token(CMD_PUSH, -32'sd2);
        plan_token(CMD_DIV, '0);
        plan_token(CMD_PUSH, INT_MIN);
        plan_token(CMD_MUL, '1);
        // Unused codes leave everything alone.
        plan_token(CMD_SPARE_LO, '1);
        plan_token(CMD_SPARE_HI, INT_MIN);
        // Pop one entry, then push and subtract, and pop the result to empty the stack.
        plan_token(CMD_POP, '0);
        plan_token(CMD_PUSH, 32'd9);
        plan_token(CMD_SUB, '0);
        plan_token(CMD_POP, '0);

        // Random part: mostly well-formed expressions, with fills, drains and noise.
        target = planned_tokens + RANDOM_TOKENS;
        while (planned_tokens < target)
        begin
            shape = $urandom_range(0, 99);
            if (shape < 4)
            begin
                // fill to the top and push past it
                while (plan_state.fill < STACK_DEPTH)
                    plan_token(CMD_PUSH, pick_operand());
                repeat ($urandom_range(1, 3))
                    plan_token(CMD_PUSH, pick_operand());
            end
            else if (shape < 10)
            begin
                // empty the stack, then run into underflow
                while (plan_state.fill != 0)
                    plan_token(CMD_POP, $urandom());
                repeat ($urandom_range(1, 2))
                    plan_token(CMD_W'($urandom_range(CMD_ADD, CMD_POP)), $urandom());
            end
            else if (shape < 16)
            begin
                repeat ($urandom_range(1, 3))
                    plan_token(CMD_W'($urandom_range(CMD_PUSH, CMD_SPARE_HI)), $urandom());
            end
            else
            begin
                len = $urandom_range(2, 5);
                repeat (len)
                    plan_token(CMD_PUSH, pick_operand());
                repeat (len - 1)
                    plan_token(CMD_W'($urandom_range(CMD_ADD, CMD_DIV)), $urandom());
                if ($urandom_range(0, 2) == 0)
                    plan_token(CMD_POP, $urandom());
            end
        end

        // Close with a zero divisor over a single entry, so divide by zero must win
        // over underflow; every token after it is ignored by the halted core.
        while (plan_state.fill != 0)
            plan_token(CMD_POP, '0);
        div_zero_allowed = 1'b1;
        plan_token(CMD_PUSH, '0);
        plan_token(CMD_DIV, '0);
        plan_token(CMD_PUSH, INT_MAX);
        plan_token(CMD_POP, '0);
        plan_token(CMD_ADD, '0);
        plan_token(CMD_DIV, '0);
        plan_token(CMD_SPARE_HI, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every token to be taken, every result to arrive, then let things settle.
        while (pending_tokens.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
